// ===== rtl/ubfa_pkg.sv =====
// Shared types, constants and UTF-8 helpers for the byte-fallback assembler.
package ubfa_pkg;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_OTHER = 2'd1,
        KIND_END   = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_MARK = 8'h80;
    localparam logic [7:0] REPL_B0   = 8'hEF;
    localparam logic [7:0] REPL_B1   = 8'hBF;
    localparam logic [7:0] REPL_B2   = 8'hBD;
    localparam int         REPL_LEN  = 3;

    // one queued job: replacements first, then raw bytes, then an optional marker
    typedef struct packed {
        logic [2:0]      repl_cnt;
        logic [2:0]      raw_cnt;
        logic            marker;
        logic [3:0][7:0] raw;
    } job_t;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        begin
            len = 3'd1;
            if (b < 8'h80)
                len = 3'd1;
            else if (b >= 8'hC0 && b <= 8'hDF)
                len = 3'd2;
            else if (b >= 8'hE0 && b <= 8'hEF)
                len = 3'd3;
            else if (b >= 8'hF0 && b <= 8'hF7)
                len = 3'd4;
            return len;
        end
    endfunction

    // range check of a complete sequence (overlong, surrogate, above U+10FFFF)
    function automatic logic seq_ok(input logic [2:0] len, input logic [7:0] b0,
                                    input logic [7:0] b1, input logic [7:0] b2,
                                    input logic [7:0] b3);
        logic [20:0] cp;
        logic        ok;
        begin
            ok = 1'b0;
            cp = '0;
            unique case (len)
                3'd2:
                begin
                    cp = {10'd0, b0[4:0], b1[5:0]};
                    ok = (cp >= 21'h80);
                end
                3'd3:
                begin
                    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
                    ok = (cp >= 21'h800) && ((cp < 21'hD800) || (cp > 21'hDFFF));
                end
                3'd4:
                begin
                    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
                    ok = (cp >= 21'h10000) && (cp <= 21'h10FFFF);
                end
                default:
                    ok = 1'b0;
            endcase
            return ok;
        end
    endfunction

endpackage

// ===== rtl/ubfa_front.sv =====
// Front end: accepts tokens, tracks the open sequence and builds output jobs.
module ubfa_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [1:0]    kind,
    input  logic [7:0]    token_byte,
    output logic          push,
    output ubfa_pkg::job_t job
);
    import ubfa_pkg::*;

    logic [7:0] store_reg  [4];
    logic [7:0] store_next [4];
    logic [7:0] seq        [4];
    logic [2:0] total_reg, total_next;
    logic [2:0] seqlen_reg, seqlen_next;
    logic [2:0] lead;
    logic [2:0] new_total;
    logic       is_cont;

    always_comb
    begin
        total_next  = total_reg;
        seqlen_next = seqlen_reg;
        store_next  = store_reg;
        seq         = store_reg;
        seq[total_reg[1:0]] = token_byte;
        lead        = lead_len(token_byte);
        new_total   = total_reg + 3'd1;
        is_cont     = (token_byte & CONT_MASK) == CONT_MARK;
        job         = '0;
        if (accept)
        begin
            unique case (kind_t'(kind))
                KIND_BYTE:
                begin
                    if (total_reg != 3'd0 && is_cont)
                    begin
                        store_next[total_reg[1:0]] = token_byte;
                        total_next = new_total;
                        if (new_total >= seqlen_reg || new_total >= 3'd4)
                        begin
                            total_next  = 3'd0;
                            seqlen_next = 3'd0;
                            if (new_total == seqlen_reg &&
                                seq_ok(seqlen_reg, seq[0], seq[1], seq[2], seq[3]))
                            begin
                                job.raw_cnt = new_total;
                                for (int i = 0; i < 4; i++)
                                    job.raw[i] = seq[i];
                            end
                            else
                            begin
                                job.repl_cnt = new_total;
                            end
                        end
                    end
                    else
                    begin
                        // flush whatever is pending, then start on the new byte
                        job.repl_cnt = total_reg;
                        if (lead == 3'd1)
                        begin
                            total_next  = 3'd0;
                            seqlen_next = 3'd0;
                            if (token_byte[7])
                                job.repl_cnt = new_total;
                            else
                            begin
                                job.raw_cnt = 3'd1;
                                job.raw[0]  = token_byte;
                            end
                        end
                        else
                        begin
                            store_next[0] = token_byte;
                            total_next    = 3'd1;
                            seqlen_next   = lead;
                        end
                    end
                end
                KIND_OTHER:
                begin
                    job.repl_cnt = total_reg;
                    job.marker   = 1'b1;
                    total_next   = 3'd0;
                    seqlen_next  = 3'd0;
                end
                KIND_END:
                begin
                    job.repl_cnt = total_reg;
                    total_next   = 3'd0;
                    seqlen_next  = 3'd0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign push = accept && (job.repl_cnt != 3'd0 || job.raw_cnt != 3'd0 || job.marker);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= 3'd0;
            seqlen_reg <= 3'd0;
        end
        else
        begin
            total_reg  <= total_next;
            seqlen_reg <= seqlen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
    end

endmodule

// ===== rtl/ubfa_queue.sv =====
// Short job queue between front and back ends.
module ubfa_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ubfa_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output ubfa_pkg::job_t head
);
    import ubfa_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign valid   = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== rtl/ubfa_back.sv =====
// Back end: expands queued jobs into output words behind an output register, one per ready cycle.
module ubfa_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  ubfa_pkg::job_t q_job,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic [0:0]     m_tuser,
    output logic           m_tlast
);
    import ubfa_pkg::*;

    job_t       cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [1:0] tri_reg, tri_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg, out_data_next;
    logic       out_slot_reg, out_slot_next;
    logic       out_last_reg, out_last_next;

    job_t       step;
    logic [1:0] tri_step, idx_step;
    logic [7:0] item_byte;
    logic       item_slot;
    logic       item_last;
    logic       load_out, emit, take;

    always_comb
    begin
        step      = cur_reg;
        tri_step  = tri_reg;
        idx_step  = idx_reg;
        item_byte = 8'h00;
        item_slot = 1'b0;
        if (cur_reg.repl_cnt != 3'd0)
        begin
            case (tri_reg)
                2'd0:    item_byte = REPL_B0;
                2'd1:    item_byte = REPL_B1;
                default: item_byte = REPL_B2;
            endcase
            if (tri_reg == 2'(REPL_LEN - 1))
            begin
                tri_step      = 2'd0;
                step.repl_cnt = cur_reg.repl_cnt - 3'd1;
            end
            else
                tri_step = tri_reg + 2'd1;
        end
        else if (cur_reg.raw_cnt != 3'd0)
        begin
            item_byte    = cur_reg.raw[idx_reg];
            idx_step     = idx_reg + 2'd1;
            step.raw_cnt = cur_reg.raw_cnt - 3'd1;
        end
        else
        begin
            item_slot   = 1'b1;
            step.marker = 1'b0;
        end
        item_last = (step.repl_cnt == 3'd0) && (step.raw_cnt == 3'd0) && !step.marker;
    end

    assign load_out = !out_valid_reg || m_tready;
    assign emit     = cur_valid_reg && load_out;
    assign take     = q_valid && (!cur_valid_reg || (emit && item_last));
    assign q_pop    = take;

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        tri_next       = tri_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_slot_next  = out_slot_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = item_byte;
            out_slot_next  = item_slot;
            out_last_next  = item_last;
            cur_next       = step;
            tri_next       = tri_step;
            idx_next       = idx_step;
            cur_valid_next = !item_last;
        end
        else if (m_tready)
            out_valid_next = 1'b0;
        if (take)
        begin
            cur_next       = q_job;
            tri_next       = 2'd0;
            idx_next       = 2'd0;
            cur_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            tri_reg       <= 2'd0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            tri_reg       <= tri_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
        out_slot_reg <= out_slot_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_slot_reg;
    assign m_tlast    = out_last_reg;

endmodule

// ===== rtl/utf8_byte_fallback_assembler_core.sv =====
// Top level of the UTF-8 byte-fallback assembler.
// Tokens enter on the s_ side, one word per cycle while a job slot is free; UTF-8
// output words leave on the m_ side, one per cycle while m_tready is high, the
// final word of each token flagged by tlast. Output bandwidth sets the rate: a
// token yields 0 to 12 words (ASCII and continuation bytes that close a valid
// sequence emit one word per byte, each replaced byte three words EF BF BD, an
// other token one marker word with tuser set), so a plain ASCII stream runs at
// one token per cycle while the sink keeps up, and replacement bursts hold the
// input while the job queue (QUEUE_DEPTH jobs) is full.
module utf8_byte_fallback_assembler_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] token_byte
    input  logic [1:0] s_tuser,   // [1:0] token_kind
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] utf8_byte
    output logic [0:0] m_tuser,   // [0] token_slot
    output logic       m_tlast
);
    import ubfa_pkg::*;

    logic accept;
    logic push;
    logic full;
    logic q_valid;
    logic q_pop;
    job_t push_job;
    job_t q_head;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    ubfa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .kind       (s_tuser),
        .token_byte (s_tdata),
        .push       (push),
        .job        (push_job)
    );

    ubfa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    ubfa_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_job    (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 8'h00)
        else $error("marker word carries nonzero data");

    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("marker word is not the last word of its token");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into a full queue");

    a_full_valid: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> q_valid)
        else $error("queue reports full and empty together");

endmodule

// ===== tb/utf8_fallback_checker.sv =====
// Output checker for the UTF-8 byte-fallback assembler: predicts and compares every word.
module utf8_fallback_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] token_byte
    input  logic [1:0] s_tuser,   // [1:0] token_kind
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] utf8_byte
    input  logic [0:0] m_tuser,   // [0] token_slot
    input  logic       m_tlast,
    output int         fail_count,
    output int         words_waiting,
    output int         tokens_seen,
    output int         words_seen,
    output int         repl_groups,
    output int         markers
);
    import ubfa_pkg::*;

    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       token_slot;
        logic       last;
    } out_word_t;

    out_word_t  expected_words[$];
    logic [7:0] pend_bytes[4];
    logic [2:0] pend_cnt;
    logic [2:0] seq_len;
    int         fails;
    int         tokens;
    int         words;
    int         groups;
    int         marks;

    function automatic logic [2:0] announced_len(input logic [7:0] value);
        if (!value[7])
            return 3'd1;
        if (value[7:5] == 3'b110)
            return 3'd2;
        if (value[7:4] == 4'b1110)
            return 3'd3;
        if (value[7:3] == 5'b11110)
            return 3'd4;
        return 3'd1;
    endfunction

    // code point of the held sequence must be in its length's range, no surrogates
    function automatic logic legal_sequence(input logic [2:0] n);
        logic [20:0] cp;
        case (n)
            3'd2:
            begin
                cp = {10'd0, pend_bytes[0][4:0], pend_bytes[1][5:0]};
                return cp >= 21'h80;
            end
            3'd3:
            begin
                cp = {5'd0, pend_bytes[0][3:0], pend_bytes[1][5:0], pend_bytes[2][5:0]};
                return cp >= 21'h800 && (cp < 21'hD800 || cp > 21'hDFFF);
            end
            3'd4:
            begin
                cp = {pend_bytes[0][2:0], pend_bytes[1][5:0], pend_bytes[2][5:0],
                      pend_bytes[3][5:0]};
                return cp >= 21'h10000 && cp <= 21'h10FFFF;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic emit(input logic [7:0] value, input logic slot);
        out_word_t w;
        w.utf8_byte  = value;
        w.token_slot = slot;
        w.last       = 1'b0;
        expected_words.push_back(w);
    endtask

    task automatic emit_replacements(input int n);
        for (int i = 0; i < n; i++)
        begin
            emit(REPL_B0, 1'b0);
            emit(REPL_B1, 1'b0);
            emit(REPL_B2, 1'b0);
        end
        groups += n;
    endtask

    task automatic flush_pending();
        emit_replacements(int'(pend_cnt));
        pend_cnt = '0;
        seq_len  = '0;
    endtask

    task automatic open_sequence(input logic [7:0] value);
        logic [2:0] len;
        len = announced_len(value);
        if (len == 3'd1)
        begin
            if (value[7])
                emit_replacements(1);
            else
                emit(value, 1'b0);
            pend_cnt = '0;
            seq_len  = '0;
        end
        else
        begin
            pend_bytes[0] = value;
            pend_cnt      = 3'd1;
            seq_len       = len;
        end
    endtask

    task automatic take_byte(input logic [7:0] value);
        if (pend_cnt == 3'd0)
            open_sequence(value);
        else if ((value & CONT_MASK) != CONT_MARK)
        begin
            flush_pending();
            open_sequence(value);
        end
        else
        begin
            pend_bytes[pend_cnt[1:0]] = value;
            pend_cnt = pend_cnt + 3'd1;
            if (pend_cnt >= seq_len || pend_cnt >= 3'd4)
            begin
                if (pend_cnt == seq_len && legal_sequence(seq_len))
                begin
                    for (int i = 0; i < int'(pend_cnt); i++)
                        emit(pend_bytes[i], 1'b0);
                    pend_cnt = '0;
                    seq_len  = '0;
                end
                else
                    flush_pending();
            end
        end
    endtask

    task automatic predict_token(input kind_t kind, input logic [7:0] value);
        int queued_before;
        queued_before = expected_words.size();
        case (kind)
            KIND_BYTE:
                take_byte(value);
            KIND_OTHER:
            begin
                flush_pending();
                emit(8'h00, 1'b1);
                marks++;
            end
            KIND_END:
                flush_pending();
            default:
                ;
        endcase
        if (expected_words.size() > queued_before)
            expected_words[expected_words.size() - 1].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t seen;
        out_word_t want;
        if (!rst_n)
        begin
            expected_words.delete();
            pend_cnt      = '0;
            seq_len       = '0;
            fails         = 0;
            tokens        = 0;
            words         = 0;
            groups        = 0;
            marks         = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                tokens++;
                predict_token(kind_t'(s_tuser), s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                words++;
                seen.utf8_byte  = m_tdata;
                seen.token_slot = m_tuser[0];
                seen.last       = m_tlast;
                if (expected_words.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected word byte=%02h slot=%0b last=%0b",
                                 $time, seen.utf8_byte, seen.token_slot, seen.last);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (want.utf8_byte !== seen.utf8_byte
                        || want.token_slot !== seen.token_slot
                        || want.last !== seen.last)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display({"%0t: word mismatch, expected byte=%02h slot=%0b last=%0b,",
                                      " got byte=%02h slot=%0b last=%0b"}, $time,
                                     want.utf8_byte, want.token_slot, want.last,
                                     seen.utf8_byte, seen.token_slot, seen.last);
                    end
                end
            end
        end
        fail_count    <= fails;
        words_waiting <= expected_words.size();
        tokens_seen   <= tokens;
        words_seen    <= words;
        repl_groups   <= groups;
        markers       <= marks;
    end

endmodule

// ===== tb/tb_utf8_byte_fallback_assembler_core.sv =====
// Testbench top for the UTF-8 byte-fallback assembler: token stimulus, stalls and verdict.
module tb_utf8_byte_fallback_assembler_core;
    import ubfa_pkg::*;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = '0;
    logic [1:0] s_tuser  = '0;
    logic       m_tready = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic [0:0] m_tuser;
    logic       m_tlast;

    int fail_count;
    int words_waiting;
    int tokens_seen;
    int words_seen;
    int repl_groups;
    int markers;
    int send_idle_pct = 38;
    int recv_idle_pct = 88;
    int tokens_sent   = 0;

    logic [7:0]  boundary_leads[12] = '{8'hC0, 8'hC1, 8'hC2, 8'hDF, 8'hE0, 8'hE1,
                                        8'hED, 8'hEF, 8'hF0, 8'hF4, 8'hF5, 8'hF7};
    logic [20:0] corner_points[12]  = '{21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hD7FF,
                                        21'hD800, 21'hDFFF, 21'hE000, 21'hFFFD,
                                        21'hFFFF, 21'h10000, 21'h10FFFF};

    utf8_byte_fallback_assembler_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    utf8_fallback_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .words_waiting (words_waiting),
        .tokens_seen   (tokens_seen),
        .words_seen    (words_seen),
        .repl_groups   (repl_groups),
        .markers       (markers)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // valid stays high across back-to-back words; it only drops for a gap
    task automatic send_token(input kind_t kind, input logic [7:0] value);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_tready);
        if (kind != KIND_NONE)
            tokens_sent++;
    endtask

    task automatic drain_block();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (words_waiting != 0);
        repeat (6) @(posedge clk);
    endtask

    function automatic logic [7:0] continuation();
        return {2'b10, 6'($urandom)};
    endfunction

    function automatic int seq_bytes(input logic [7:0] lead);
        if (lead[7:5] == 3'b110)
            return 2;
        if (lead[7:4] == 4'b1110)
            return 3;
        if (lead[7:3] == 5'b11110)
            return 4;
        return 1;
    endfunction

    function automatic logic [20:0] random_codepoint();
        case ($urandom_range(4))
            0:       return 21'($urandom_range(32'h7F, 0));
            1:       return 21'($urandom_range(32'h7FF, 32'h80));
            2:       return 21'($urandom_range(32'hFFFF, 32'h800));
            3:       return 21'($urandom_range(32'h10FFFF, 32'h10000));
            default: return corner_points[$urandom_range(11)];
        endcase
    endfunction

    task automatic send_codepoint(input logic [20:0] cp);
        if (cp < 21'h80)
            send_token(KIND_BYTE, {1'b0, cp[6:0]});
        else if (cp < 21'h800)
        begin
            send_token(KIND_BYTE, {3'b110, cp[10:6]});
            send_token(KIND_BYTE, {2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            send_token(KIND_BYTE, {4'b1110, cp[15:12]});
            send_token(KIND_BYTE, {2'b10, cp[11:6]});
            send_token(KIND_BYTE, {2'b10, cp[5:0]});
        end
        else
        begin
            send_token(KIND_BYTE, {5'b11110, cp[20:18]});
            send_token(KIND_BYTE, {2'b10, cp[17:12]});
            send_token(KIND_BYTE, {2'b10, cp[11:6]});
            send_token(KIND_BYTE, {2'b10, cp[5:0]});
        end
    endtask

    task automatic send_random_unit();
        int         pick;
        int         n;
        logic [7:0] lead;
        pick = $urandom_range(99);
        if (pick < 40)
            send_codepoint(random_codepoint());
        else if (pick < 58)
        begin
            // full-length sequence on a lead near a range limit
            lead = boundary_leads[$urandom_range(11)];
            send_token(KIND_BYTE, lead);
            repeat (seq_bytes(lead) - 1) send_token(KIND_BYTE, continuation());
        end
        else if (pick < 70)
        begin
            // sequence cut short by something other than a continuation
            lead = 8'($urandom_range(32'hF4, 32'hC2));
            n    = $urandom_range(seq_bytes(lead) - 2, 0);
            send_token(KIND_BYTE, lead);
            repeat (n) send_token(KIND_BYTE, continuation());
            case ($urandom_range(3))
                0:       send_token(KIND_BYTE, 8'($urandom_range(32'h7F, 0)));
                1:       send_token(KIND_BYTE, 8'($urandom_range(32'hF7, 32'hC0)));
                2:       send_token(KIND_OTHER, 8'($urandom));
                default: send_token(KIND_END, 8'($urandom));
            endcase
        end
        else if (pick < 80)
            send_token(KIND_OTHER, 8'($urandom));
        else if (pick < 85)
            send_token(KIND_END, 8'($urandom));
        else if (pick < 95)
            send_token(KIND_BYTE, 8'($urandom));
        else
            send_token(KIND_NONE, 8'($urandom));
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_token(KIND_BYTE, 8'h00);
        send_token(KIND_BYTE, 8'h7F);
        send_token(KIND_BYTE, 8'hDF);
        send_token(KIND_BYTE, 8'hBF);
        send_token(KIND_BYTE, 8'hC0);   // overlong two-byte form
        send_token(KIND_BYTE, 8'h80);
        send_token(KIND_BYTE, 8'hEF);   // encoded U+FFFD passes unchanged
        send_token(KIND_BYTE, 8'hBF);
        send_token(KIND_BYTE, 8'hBD);
        send_token(KIND_BYTE, 8'hF4);   // above U+10FFFF: four replacements
        send_token(KIND_BYTE, 8'h90);
        send_token(KIND_BYTE, 8'h80);
        send_token(KIND_BYTE, 8'h80);
        send_token(KIND_BYTE, 8'h80);   // lone continuation
        send_token(KIND_BYTE, 8'hFF);
        send_token(KIND_BYTE, 8'hE2);   // interrupted by ASCII
        send_token(KIND_BYTE, 8'h82);
        send_token(KIND_BYTE, 8'h41);
        send_token(KIND_BYTE, 8'hC3);
        send_token(KIND_OTHER, 8'hA5);
        send_token(KIND_BYTE, 8'hF0);   // unfinished at end of stream
        send_token(KIND_BYTE, 8'h9F);
        send_token(KIND_END, 8'h5A);
        send_token(KIND_END, 8'hFF);
        send_token(KIND_NONE, 8'hAA);

        while (tokens_sent < 90)
            send_random_unit();
        drain_block();

        send_idle_pct = 88;
        recv_idle_pct <= 38;
        while (tokens_sent < 160)
            send_random_unit();
        drain_block();

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        while (tokens_sent < 230)
            send_random_unit();
        drain_block();

        $display("Run covered %0d tokens under three stall mixes and checked %0d output words,",
                 tokens_seen, words_seen);
        $display("including %0d replacement groups and %0d token markers.",
                 repl_groups, markers);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timed out with %0d words still expected.", words_waiting);
        $display("== FAIL ==");
        $finish;
    end

endmodule
